// ----- sv/mhnt_pkg.sv -----
// Package for the held MIDI note table: item codes, command and result types.
// Used by every module of the block; depends on nothing.

package mhnt_pkg;

    localparam int MAX_HELD_DEF = 32;

    localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
    localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;

    typedef enum logic [1:0] {
        ACT_MSG   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        K_IGNORE,
        K_NOTE_ON,
        K_NOTE_OFF,
        K_READ,
        K_CLEAR
    } t_kind;

    typedef enum logic [2:0] {
        OC_IGNORED    = 3'd0,
        OC_STORED     = 3'd1,
        OC_RETRIGGER  = 3'd2,
        OC_DROPPED    = 3'd3,
        OC_RELEASED   = 3'd4,
        OC_UNMATCHED  = 3'd5,
        OC_READ       = 3'd6,
        OC_CLEARED    = 3'd7
    } t_outcome;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_FIND,
        BS_APPLY
    } t_bstate;

    typedef struct packed {
        logic [7:0]  port;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [7:0]  source;
        logic [31:0] first_tick;
    } t_entry;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  port;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] tick;
        logic [7:0]  source;
        logic [4:0]  read_index;
    } t_cmd;

    typedef struct packed {
        t_outcome    outcome;
        logic [5:0]  held_count;
        logic        overflowed;
        logic        entry_valid;
        t_entry      entry;
    } t_result;

endpackage

// ----- sv/midi_held_note_table.sv -----
// Held MIDI note table, top level: front end, command queue, table engine.
// Path to m_axis: queue slot, command register, match registers, output register.
// The engine takes one transaction at a time through its idle, find and apply states.
// The two-entry queue and the output register let input and output stall independently.
// Reset (i_rst_n low, synchronous) empties the table, the queue and the overflow flag.
// Depends on mhnt_pkg, mhnt_front, mhnt_queue, mhnt_back.

module midi_held_note_table #(
    parameter int MAX_HELD = mhnt_pkg::MAX_HELD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // port, status_byte, data1, data2, tick,
                                        // source_tag, read_index, zero fill
    input  logic [1:0]  s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // held_count, overflowed, entry_valid, entry_port,
                                        // entry_channel, entry_note, entry_velocity,
                                        // entry_source, entry_first_tick, zero fill
    output logic [2:0]  m_axis_tuser    // outcome
);

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_q_valid;
    mhnt_pkg::t_cmd    w_in_cmd;
    mhnt_pkg::t_cmd    w_q_cmd;
    mhnt_pkg::t_result w_res;

    mhnt_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (w_full),
        .o_push        (w_push),
        .o_cmd         (w_in_cmd)
    );

    mhnt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_in_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    mhnt_back #(
        .MAX_HELD (MAX_HELD)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tuser = w_res.outcome;
    assign m_axis_tdata = {6'd0, w_res.entry.first_tick, w_res.entry.source,
                           w_res.entry.velocity, w_res.entry.note, w_res.entry.channel,
                           w_res.entry.port, w_res.entry_valid, w_res.overflowed,
                           w_res.held_count};

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == mhnt_pkg::OC_CLEARED) |->
        (m_axis_tdata[6:0] == 7'd0))
        else $error("clear result reports held notes or overflow");

    a_drop_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == mhnt_pkg::OC_DROPPED) |-> m_axis_tdata[6])
        else $error("dropped note without overflow flag");

    a_valid_only_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7]) |->
        (m_axis_tuser == mhnt_pkg::OC_READ &&
         (m_axis_tdata[5:0] != 6'd0 || MAX_HELD >= 64)))
        else $error("entry valid outside a read of a non-empty table");

    a_store_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == mhnt_pkg::OC_STORED) |->
        (m_axis_tdata[5:0] != 6'd0 || MAX_HELD >= 64))
        else $error("stored note with zero held count");

endmodule

// ----- sv/mhnt_front.sv -----
// Front end of the held note table: accepts stream transactions and classifies them.
// Depends on mhnt_pkg.

module mhnt_front (
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [79:0]          s_axis_tdata,   // port, status_byte, data1, data2, tick,
                                                 // source_tag, read_index, zero fill
    input  logic [1:0]           s_axis_tuser,   // action
    input  logic                 i_q_full,
    output logic                 o_push,
    output mhnt_pkg::t_cmd       o_cmd
);

    logic [7:0] w_status;
    logic [6:0] w_vel;

    assign w_status      = s_axis_tdata[15:8];
    assign w_vel         = s_axis_tdata[29:23];
    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_cmd.port       = s_axis_tdata[7:0];
        o_cmd.channel    = w_status[3:0];
        o_cmd.note       = s_axis_tdata[22:16];
        o_cmd.velocity   = w_vel;
        o_cmd.tick       = s_axis_tdata[61:30];
        o_cmd.source     = s_axis_tdata[69:62];
        o_cmd.read_index = s_axis_tdata[74:70];
        case (mhnt_pkg::t_action'(s_axis_tuser))
            mhnt_pkg::ACT_MSG: begin
                if (w_status[7:4] == mhnt_pkg::MIDI_NOTE_ON && w_vel != 7'd0) begin
                    o_cmd.kind = mhnt_pkg::K_NOTE_ON;
                end else if (w_status[7:4] == mhnt_pkg::MIDI_NOTE_OFF ||
                             w_status[7:4] == mhnt_pkg::MIDI_NOTE_ON) begin
                    o_cmd.kind = mhnt_pkg::K_NOTE_OFF;
                end else begin
                    o_cmd.kind = mhnt_pkg::K_IGNORE;
                end
            end
            mhnt_pkg::ACT_READ:  o_cmd.kind = mhnt_pkg::K_READ;
            mhnt_pkg::ACT_CLEAR: o_cmd.kind = mhnt_pkg::K_CLEAR;
            default:             o_cmd.kind = mhnt_pkg::K_IGNORE;
        endcase
    end

endmodule

// ----- sv/mhnt_queue.sv -----
// Two-entry command queue between the front end and the table engine.
// Depends on mhnt_pkg.

module mhnt_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mhnt_pkg::t_cmd       i_cmd,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output mhnt_pkg::t_cmd       o_cmd
);

    mhnt_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- sv/mhnt_back.sv -----
// Table engine: holds the note entries, finds matches, applies commands, registers results.
// Depends on mhnt_pkg.

module mhnt_back #(
    parameter int MAX_HELD = mhnt_pkg::MAX_HELD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  mhnt_pkg::t_cmd       i_q_cmd,
    output logic                 o_pop,
    output logic                 o_res_valid,
    output mhnt_pkg::t_result    o_res,
    input  logic                 i_res_ready
);

    localparam int CW = $clog2(MAX_HELD + 1);
    localparam int IW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;

    mhnt_pkg::t_bstate r_state, n_state;
    mhnt_pkg::t_cmd    r_cmd;
    mhnt_pkg::t_entry  r_entries [MAX_HELD];
    logic [CW-1:0]     r_count, n_count;
    logic              r_ovf, n_ovf;
    logic              r_hit, n_hit;
    logic [IW-1:0]     r_hit_idx, n_hit_idx;
    logic              r_out_valid;
    mhnt_pkg::t_result r_out, n_out;
    logic              w_load;
    logic              w_full;
    logic              w_rd_ok;

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;
    assign w_full      = (r_count >= CW'(MAX_HELD));
    assign w_rd_ok     = (32'(r_cmd.read_index) < 32'(MAX_HELD)) &&
                         (32'(r_cmd.read_index) < 32'(r_count));

    always_comb begin
        n_state = r_state;
        case (r_state)
            mhnt_pkg::BS_IDLE:  if (i_q_valid) n_state = mhnt_pkg::BS_FIND;
            mhnt_pkg::BS_FIND:  n_state = mhnt_pkg::BS_APPLY;
            mhnt_pkg::BS_APPLY: if (!r_out_valid || i_res_ready) n_state = mhnt_pkg::BS_IDLE;
            default:            n_state = mhnt_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == mhnt_pkg::BS_IDLE) && i_q_valid;
        w_load = (r_state == mhnt_pkg::BS_APPLY) && (!r_out_valid || i_res_ready);
    end

    // first live entry that matches port, channel and note
    always_comb begin
        n_hit     = 1'b0;
        n_hit_idx = '0;
        for (int i = MAX_HELD - 1; i >= 0; i--) begin
            if (CW'(i) < r_count && r_entries[i].port == r_cmd.port &&
                r_entries[i].channel == r_cmd.channel && r_entries[i].note == r_cmd.note) begin
                n_hit     = 1'b1;
                n_hit_idx = IW'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_out   = '0;
        case (r_cmd.kind)
            mhnt_pkg::K_NOTE_ON: begin
                if (r_hit) begin
                    n_out.outcome = mhnt_pkg::OC_RETRIGGER;
                end else if (w_full) begin
                    n_ovf         = 1'b1;
                    n_out.outcome = mhnt_pkg::OC_DROPPED;
                end else begin
                    n_count       = r_count + CW'(1);
                    n_out.outcome = mhnt_pkg::OC_STORED;
                end
            end
            mhnt_pkg::K_NOTE_OFF: begin
                if (r_hit) begin
                    n_count       = r_count - CW'(1);
                    n_out.outcome = mhnt_pkg::OC_RELEASED;
                end else begin
                    n_out.outcome = mhnt_pkg::OC_UNMATCHED;
                end
            end
            mhnt_pkg::K_READ: begin
                n_out.outcome = mhnt_pkg::OC_READ;
                if (w_rd_ok) begin
                    n_out.entry_valid = 1'b1;
                    n_out.entry       = r_entries[IW'(r_cmd.read_index)];
                end
            end
            mhnt_pkg::K_CLEAR: begin
                n_count       = '0;
                n_ovf         = 1'b0;
                n_out.outcome = mhnt_pkg::OC_CLEARED;
            end
            default: n_out.outcome = mhnt_pkg::OC_IGNORED;
        endcase
        n_out.held_count = 6'(n_count);
        n_out.overflowed = n_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (r_state == mhnt_pkg::BS_FIND) begin
            r_hit_idx <= n_hit_idx;
        end
        if (w_load) begin
            r_out <= n_out;
        end
        if (w_load && r_cmd.kind == mhnt_pkg::K_NOTE_ON) begin
            if (r_hit) begin
                r_entries[r_hit_idx].velocity <= r_cmd.velocity;
            end else if (!w_full) begin
                r_entries[IW'(r_count)] <= '{port: r_cmd.port, channel: r_cmd.channel,
                                            note: r_cmd.note, velocity: r_cmd.velocity,
                                            source: r_cmd.source, first_tick: r_cmd.tick};
            end
        end
        if (w_load && r_cmd.kind == mhnt_pkg::K_NOTE_OFF && r_hit) begin
            for (int j = 0; j < MAX_HELD - 1; j++) begin
                if (IW'(j) >= r_hit_idx) begin
                    r_entries[j] <= r_entries[j + 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhnt_pkg::BS_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mhnt_pkg::BS_FIND) begin
                r_hit <= n_hit;
            end
            if (w_load) begin
                r_count     <= n_count;
                r_ovf       <= n_ovf;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- dv/midi_held_note_table_chk.sv -----
// Checker for the held MIDI note table: keeps its own copy of the table, predicts each
// result from the accepted input transactions and compares it field by field.
// Depends on mhnt_pkg for the entry, outcome and result types.

module midi_held_note_table_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [79:0] i_s_tdata,   // port, status_byte, data1, data2, tick,
                                     // source_tag, read_index, zero fill
    input  logic [1:0]  i_s_tuser,   // action
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [79:0] i_m_tdata,   // held_count, overflowed, entry_valid, entry_port,
                                     // entry_channel, entry_note, entry_velocity,
                                     // entry_source, entry_first_tick, zero fill
    input  logic [2:0]  i_m_tuser,   // outcome
    output int          o_fail_count,
    output int          o_pending
);

    localparam int TABLE_DEPTH = mhnt_pkg::MAX_HELD_DEF;

    mhnt_pkg::t_entry  held_notes [TABLE_DEPTH];
    int                held_total;
    logic              overflow_flag;
    mhnt_pkg::t_result expected_results [$];
    int                mismatches;
    int                results_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        mismatches   = 0;
        results_seen = 0;
        held_total   = 0;
        overflow_flag = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] got_v,
                                 input logic [31:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got %0h want %0h", name, got_v, want_v));
    endtask

    function automatic int find_note(input logic [7:0] port, input logic [3:0] chan,
                                     input logic [6:0] note);
        for (int i = 0; i < held_total; i++) begin
            if (held_notes[i].port == port && held_notes[i].channel == chan &&
                held_notes[i].note == note)
                return i;
        end
        return -1;
    endfunction

    function automatic mhnt_pkg::t_result apply_note_item(input logic [1:0] act,
                                                          input logic [79:0] d);
        mhnt_pkg::t_result res;
        logic [7:0]  port;
        logic [3:0]  msg_type;
        logic [3:0]  chan;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [31:0] tick;
        logic [7:0]  tag;
        logic [4:0]  idx;
        int          slot;
        port     = d[7:0];
        chan     = d[11:8];
        msg_type = d[15:12];
        note     = d[22:16];
        vel      = d[29:23];
        tick     = d[61:30];
        tag      = d[69:62];
        idx      = d[74:70];
        res = '0;
        res.outcome = mhnt_pkg::OC_IGNORED;
        case (act)
            mhnt_pkg::ACT_MSG: begin
                slot = find_note(port, chan, note);
                if (msg_type == mhnt_pkg::MIDI_NOTE_ON && vel != 7'd0) begin
                    if (slot >= 0) begin
                        held_notes[slot].velocity = vel;
                        res.outcome = mhnt_pkg::OC_RETRIGGER;
                    end else if (held_total >= TABLE_DEPTH) begin
                        overflow_flag = 1'b1;
                        res.outcome = mhnt_pkg::OC_DROPPED;
                    end else begin
                        held_notes[held_total].port       = port;
                        held_notes[held_total].channel    = chan;
                        held_notes[held_total].note       = note;
                        held_notes[held_total].velocity   = vel;
                        held_notes[held_total].source     = tag;
                        held_notes[held_total].first_tick = tick;
                        held_total++;
                        res.outcome = mhnt_pkg::OC_STORED;
                    end
                end else if (msg_type == mhnt_pkg::MIDI_NOTE_OFF ||
                             msg_type == mhnt_pkg::MIDI_NOTE_ON) begin
                    if (slot >= 0) begin
                        for (int j = slot; j + 1 < held_total; j++)
                            held_notes[j] = held_notes[j + 1];
                        held_total--;
                        res.outcome = mhnt_pkg::OC_RELEASED;
                    end else begin
                        res.outcome = mhnt_pkg::OC_UNMATCHED;
                    end
                end
            end
            mhnt_pkg::ACT_READ: begin
                res.outcome = mhnt_pkg::OC_READ;
                if (int'(idx) < held_total) begin
                    res.entry_valid = 1'b1;
                    res.entry       = held_notes[idx];
                end
            end
            mhnt_pkg::ACT_CLEAR: begin
                held_total    = 0;
                overflow_flag = 1'b0;
                res.outcome   = mhnt_pkg::OC_CLEARED;
            end
            default: res.outcome = mhnt_pkg::OC_IGNORED;
        endcase
        res.held_count = held_total[5:0];
        res.overflowed = overflow_flag;
        return res;
    endfunction

    task automatic check_result();
        mhnt_pkg::t_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("no transaction pending for this result");
        end else begin
            want = expected_results.pop_front();
            compare_field("outcome", 32'(i_m_tuser), 32'(want.outcome));
            compare_field("held_count", 32'(i_m_tdata[5:0]), 32'(want.held_count));
            compare_field("overflowed", 32'(i_m_tdata[6]), 32'(want.overflowed));
            compare_field("entry_valid", 32'(i_m_tdata[7]), 32'(want.entry_valid));
            compare_field("entry_port", 32'(i_m_tdata[15:8]), 32'(want.entry.port));
            compare_field("entry_channel", 32'(i_m_tdata[19:16]), 32'(want.entry.channel));
            compare_field("entry_note", 32'(i_m_tdata[26:20]), 32'(want.entry.note));
            compare_field("entry_velocity", 32'(i_m_tdata[33:27]),
                          32'(want.entry.velocity));
            compare_field("entry_source", 32'(i_m_tdata[41:34]), 32'(want.entry.source));
            compare_field("entry_first_tick", i_m_tdata[73:42], want.entry.first_tick);
        end
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_total    = 0;
            overflow_flag = 1'b0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                expected_results.insert(expected_results.size(),
                                        apply_note_item(i_s_tuser, i_s_tdata));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- dv/midi_held_note_table_tb.sv -----
// Testbench top for the held MIDI note table: clock, reset, stimulus on both stream
// sides and the verdict. Depends on mhnt_pkg, midi_held_note_table, midi_held_note_table_chk.

module midi_held_note_table_tb;

    localparam int         STALL_LIMIT   = 3000;
    localparam int         LONG_HOLD     = 400;
    localparam int         DRAIN_CYCLES  = 10;
    localparam logic [1:0] ACT_UNDEFINED = 2'd3;
    localparam logic [3:0] MIDI_DATA     = 4'h7;
    localparam logic [3:0] MIDI_POLY_AT  = 4'hA;
    localparam logic [3:0] MIDI_CONTROL  = 4'hB;
    localparam logic [3:0] MIDI_SYSTEM   = 4'hF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    int fail_count;
    int pending;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int sink_hold_cycles = 0;
    int stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    midi_held_note_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    midi_held_note_table_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("midi_held_note_table: mismatch");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : sink_proc
        int burst;
        forever begin
            if (sink_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                burst = sink_hold_cycles;
                sink_hold_cycles = 0;
                repeat (burst) @(posedge i_clk);
            end else if (sink_idle_pct > 0 && $urandom_range(99) < sink_idle_pct) begin
                m_axis_tready <= 1'b0;
                burst = $urandom_range(19, 1);
                repeat (burst) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [79:0] pack_item(input logic [7:0] port, input logic [7:0] status,
                                              input logic [6:0] note, input logic [6:0] vel,
                                              input logic [31:0] tick, input logic [7:0] tag,
                                              input logic [4:0] idx);
        return {5'd0, idx, tag, tick, vel, note, status, port};
    endfunction

    // Leave the item valid after acceptance so a back-to-back item needs no second update.
    task automatic send_item(input logic [1:0] act, input logic [79:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_note(input logic [7:0] port, input logic [7:0] status,
                             input logic [6:0] note, input logic [6:0] vel,
                             input logic [31:0] tick, input logic [7:0] tag);
        send_item(mhnt_pkg::ACT_MSG, pack_item(port, status, note, vel, tick, tag,
                                               5'($urandom)));
    endtask

    task automatic send_control(input logic [1:0] act, input logic [4:0] idx);
        send_item(act, pack_item(8'($urandom), 8'($urandom), 7'($urandom), 7'($urandom),
                                 $urandom, 8'($urandom), idx));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_random_item(input int on_pct, input int off_pct);
        int         roll;
        int         sel;
        logic [7:0] port;
        logic [7:0] status;
        logic [3:0] chan;
        logic [6:0] note;
        logic [6:0] vel;
        logic [1:0] act;
        roll = $urandom_range(99);
        sel  = $urandom_range(99);
        if ($urandom_range(9) < 8) begin
            port = ($urandom_range(1) ? 8'hFF : 8'h00) ^ 8'($urandom_range(1));
            chan = $urandom_range(1) ? 4'hF : 4'h0;
            note = 7'(60 + $urandom_range(7));
        end else begin
            port = 8'($urandom);
            chan = 4'($urandom);
            note = 7'($urandom);
        end
        vel = 7'($urandom);
        act = mhnt_pkg::ACT_MSG;
        if (roll < on_pct) begin
            status = {mhnt_pkg::MIDI_NOTE_ON, chan};
            if (vel == 7'd0)
                vel = 7'd1;
        end else if (roll < on_pct + off_pct) begin
            if (sel < 50) begin
                status = {mhnt_pkg::MIDI_NOTE_OFF, chan};
            end else begin
                status = {mhnt_pkg::MIDI_NOTE_ON, chan};
                vel    = 7'd0;
            end
        end else begin
            status = 8'($urandom);
            // turn note types into aftertouch or control change
            if (status[7:5] == 3'b100)
                status[5] = 1'b1;
            if (sel < 60)
                act = mhnt_pkg::ACT_READ;
            else if (sel < 85)
                act = mhnt_pkg::ACT_MSG;
            else if (sel < 93)
                act = ACT_UNDEFINED;
            else
                act = mhnt_pkg::ACT_CLEAR;
        end
        send_item(act, pack_item(port, status, note, vel, $urandom, 8'($urandom),
                                 5'($urandom)));
    endtask

    initial begin : stim_proc
        int on_mix [8];
        on_mix = '{80, 15, 50, 85, 10, 45, 70, 40};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 30;
        sink_idle_pct = 30;
        send_control(mhnt_pkg::ACT_READ, 5'd0);
        send_control(mhnt_pkg::ACT_READ, 5'd31);
        send_note(8'h00, {mhnt_pkg::MIDI_NOTE_ON, 4'h0}, 7'd0, 7'd1, 32'h0000_0000, 8'h00);
        send_note(8'hFF, {mhnt_pkg::MIDI_NOTE_ON, 4'hF}, 7'd127, 7'd127, 32'hFFFF_FFFF,
                  8'hFF);
        send_note(8'h00, {mhnt_pkg::MIDI_NOTE_ON, 4'h1}, 7'd0, 7'd64, 32'h0000_0010, 8'h11);
        send_note(8'h01, {mhnt_pkg::MIDI_NOTE_ON, 4'h0}, 7'd0, 7'd64, 32'h0000_0020, 8'h22);
        send_note(8'h00, {mhnt_pkg::MIDI_NOTE_ON, 4'h0}, 7'd0, 7'd127, 32'h0000_1234, 8'h55);
        send_control(mhnt_pkg::ACT_READ, 5'd0);
        send_control(mhnt_pkg::ACT_READ, 5'd1);
        send_note(8'h00, {mhnt_pkg::MIDI_NOTE_OFF, 4'h0}, 7'd0, 7'd64, $urandom,
                  8'($urandom));
        send_control(mhnt_pkg::ACT_READ, 5'd0);
        send_note(8'hFF, {mhnt_pkg::MIDI_NOTE_ON, 4'hF}, 7'd127, 7'd0, $urandom,
                  8'($urandom));
        send_note(8'h09, {mhnt_pkg::MIDI_NOTE_OFF, 4'h3}, 7'd12, 7'd40, $urandom,
                  8'($urandom));
        send_note(8'h00, {mhnt_pkg::MIDI_NOTE_ON, 4'h5}, 7'd5, 7'd0, $urandom,
                  8'($urandom));
        send_note(8'h00, {MIDI_POLY_AT, 4'h0}, 7'd0, 7'd90, $urandom, 8'($urandom));
        send_note(8'h00, {MIDI_DATA, 4'hF}, 7'd0, 7'd90, $urandom, 8'($urandom));
        send_note(8'h00, {MIDI_SYSTEM, 4'h0}, 7'd0, 7'd90, $urandom, 8'($urandom));
        send_note(8'h01, {MIDI_CONTROL, 4'hF}, 7'd0, 7'd90, $urandom, 8'($urandom));
        send_item(ACT_UNDEFINED, pack_item(8'h00, {mhnt_pkg::MIDI_NOTE_ON, 4'h0}, 7'd9,
                                           7'd9, $urandom, 8'h09, 5'd0));
        send_control(mhnt_pkg::ACT_READ, 5'd3);
        send_control(mhnt_pkg::ACT_CLEAR, 5'd0);
        send_control(mhnt_pkg::ACT_READ, 5'd0);

        // fill past capacity, release from the middle, refill and clear
        for (int i = 0; i < 34; i++)
            send_note(8'(i), {mhnt_pkg::MIDI_NOTE_ON, 4'(i)}, 7'(127 - i), 7'(i + 1),
                      $urandom, 8'(i));
        send_control(mhnt_pkg::ACT_READ, 5'd31);
        send_control(mhnt_pkg::ACT_READ, 5'd0);
        send_note(8'd5, {mhnt_pkg::MIDI_NOTE_OFF, 4'd5}, 7'd122, 7'd0, $urandom,
                  8'($urandom));
        send_control(mhnt_pkg::ACT_READ, 5'd5);
        send_control(mhnt_pkg::ACT_READ, 5'd31);
        send_note(8'd77, {mhnt_pkg::MIDI_NOTE_ON, 4'd7}, 7'd7, 7'd77, $urandom, 8'd77);
        send_note(8'd78, {mhnt_pkg::MIDI_NOTE_ON, 4'd8}, 7'd8, 7'd78, $urandom, 8'd78);
        send_control(mhnt_pkg::ACT_READ, 5'd31);
        send_control(mhnt_pkg::ACT_CLEAR, 5'd0);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            src_idle_pct  = (ph == 7) ? 0 : 10 * $urandom_range(4);
            sink_idle_pct = (ph == 7) ? 0 : 10 * $urandom_range(4);
            if (ph == 1)
                sink_hold_cycles = LONG_HOLD;
            if (ph == 4)
                drain_results();
            repeat (205) send_random_item(on_mix[ph], 85 - on_mix[ph]);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("midi_held_note_table: match");
        else
            $display("midi_held_note_table: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mhnt_pkg.sv
sv/mhnt_front.sv
sv/mhnt_queue.sv
sv/mhnt_back.sv
sv/midi_held_note_table.sv
dv/midi_held_note_table_chk.sv
dv/midi_held_note_table_tb.sv
